// File: rtl/obst_pkg.sv
package obst_pkg;

   // key capacity and derived table geometry
   localparam int MAX_KEYS  = 9;
   localparam int SLOTS     = MAX_KEYS + 1;
   localparam int TBL_DEPTH = SLOTS * SLOTS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   // field widths fixed by the item format
   localparam int IDX_W   = 4;
   localparam int WGT_W   = 8;
   localparam int SUM_W   = 13;
   localparam int COST_W  = 16;
   localparam int BEST_W  = COST_W + 1;
   localparam int ALU_W   = COST_W + 2;

   // one write to the weight, cost and root tables
   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [SUM_W-1:0]  w;
      logic [COST_W-1:0] c;
      logic [IDX_W-1:0]  r;
   } tbl_wr_type;

   // read addresses: weight, cost port a (also root), cost port b
   typedef struct packed {
      logic [TBL_AW-1:0] w_addr;
      logic [TBL_AW-1:0] ca_addr;
      logic [TBL_AW-1:0] cb_addr;
   } tbl_rd_type;

   // registered read data
   typedef struct packed {
      logic [SUM_W-1:0]  w;
      logic [COST_W-1:0] ca;
      logic [COST_W-1:0] cb;
      logic [IDX_W-1:0]  r;
   } tbl_data_type;

   // flat table address of entry (row, col)
   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
      return TBL_AW'(row) * TBL_AW'(SLOTS) + TBL_AW'(col);
   endfunction

endpackage

// File: rtl/obst_tables.sv
module obst_tables import obst_pkg::*; (
   input  logic         clock,
   input  tbl_wr_type   wr,
   input  tbl_rd_type   rd,
   output tbl_data_type rd_data
);

   logic [SUM_W-1:0]  weight_mem [TBL_DEPTH];
   logic [COST_W-1:0] cost_mem   [TBL_DEPTH];
   logic [IDX_W-1:0]  root_mem   [TBL_DEPTH];

   // single write port shared by all three tables
   always_ff @(posedge clock) begin
      if (wr.we) begin
         weight_mem[wr.addr] <= wr.w;
         cost_mem[wr.addr]   <= wr.c;
         root_mem[wr.addr]   <= wr.r;
      end
   end

   // registered reads; cost has two ports
   always_ff @(posedge clock) begin
      rd_data.w  <= weight_mem[rd.w_addr];
      rd_data.ca <= cost_mem[rd.ca_addr];
      rd_data.cb <= cost_mem[rd.cb_addr];
      rd_data.r  <= root_mem[rd.ca_addr];
   end

endmodule

// File: rtl/obst_alu.sv
module obst_alu import obst_pkg::*; (
   input  logic [ALU_W-1:0] opnd_a,
   input  logic [ALU_W-1:0] opnd_b,
   input  logic [ALU_W-1:0] cmp_ref,
   output logic [ALU_W-1:0] sum,
   output logic             sum_lt
);

   // shared adder with a compare against the running best
   assign sum    = opnd_a + opnd_b;
   assign sum_lt = sum < cmp_ref;

endmodule

// File: rtl/optimal_bst_cost_table_core.sv
// Optimal binary search tree cost table. Keys load one item per cycle: item k
// stores success weight p[k] and failure weight q[k]; the item with
// end_of_load set (or the item at position MAX_KEYS) closes the load of n+1
// positions and starts the table build. req_stall stays high from then on
// until the last result has entered the output register.
// The build first fills the diagonal, then each entry (i,j) with j > i in
// turn: one shared adder/comparator walks the candidate roots and each
// candidate waits on a registered two-port read of the cost table. The
// results, every (i,j) diagonal by diagonal with i ascending, then leave one
// at a time, each after a registered table read, and wait while rsp_stall is
// held; the last item, range 0..n, has final_entry set.
// Costs saturate at 65535 and ties pick the lowest root. A new load may start
// while the last result still waits in the output register.
module optimal_bst_cost_table_core import obst_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [WGT_W-1:0]   req_success_weight,
   input  logic [WGT_W-1:0]   req_failure_weight,
   input  logic               req_end_of_load,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_left_bound,
   output logic [IDX_W-1:0]   rsp_right_bound,
   output logic [SUM_W-1:0]   rsp_subtree_weight,
   output logic [COST_W-1:0]  rsp_subtree_cost,
   output logic [IDX_W-1:0]   rsp_best_root,
   output logic               rsp_final_entry
);

   typedef enum logic [8:0] {
      ST_LOAD     = 9'b000000001,
      ST_INIT     = 9'b000000010,
      ST_CELL_RD  = 9'b000000100,
      ST_CELL_CMP = 9'b000001000,
      ST_W_ADDP   = 9'b000010000,
      ST_W_ADDQ   = 9'b000100000,
      ST_CELL_WR  = 9'b001000000,
      ST_EMIT_RD  = 9'b010000000,
      ST_EMIT_OUT = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   load_pos_ff, load_pos_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   d_ff, d_in;
   logic [IDX_W-1:0]   m_ff, m_in;
   logic [BEST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [SUM_W-1:0]   wacc_ff, wacc_in;
   logic [WGT_W-1:0]   p_store_ff [SLOTS];
   logic [WGT_W-1:0]   q_store_ff [SLOTS];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [IDX_W-1:0]   rsp_right_ff, rsp_right_in;
   logic [SUM_W-1:0]   rsp_weight_ff, rsp_weight_in;
   logic [COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic [IDX_W-1:0]   rsp_root_ff, rsp_root_in;
   logic               rsp_final_ff, rsp_final_in;

   logic [IDX_W-1:0]   j_idx;
   logic [IDX_W-1:0]   q_idx;
   logic [WGT_W-1:0]   p_rd, q_rd;
   logic               load_take;
   logic               load_last;
   logic               out_free;
   logic               first_cand;
   logic [COST_W-1:0]  cost_sat;

   tbl_wr_type         tbl_wr;
   tbl_rd_type         tbl_rd;
   tbl_data_type       tbl_data;

   logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
   logic               alu_lt;

   obst_tables u_tables (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_data)
   );

   obst_alu u_alu (
      .opnd_a  (alu_a),
      .opnd_b  (alu_b),
      .cmp_ref (ALU_W'(best_ff)),
      .sum     (alu_sum),
      .sum_lt  (alu_lt)
   );

   // range end and weight store reads
   assign j_idx     = i_ff + d_ff;
   assign q_idx     = (state_ff == ST_INIT) ? i_ff : j_idx;
   assign p_rd      = p_store_ff[j_idx];
   assign q_rd      = q_store_ff[q_idx];
   assign first_cand = (m_ff == i_ff + IDX_W'(1));
   assign cost_sat  = (|alu_sum[ALU_W-1:COST_W]) ? {COST_W{1'b1}} : alu_sum[COST_W-1:0];

   assign req_stall = (state_ff != ST_LOAD);
   assign load_take = req_valid && !req_stall;
   assign load_last = req_end_of_load || (load_pos_ff == IDX_W'(MAX_KEYS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared adder operand select
   always_comb begin
      unique case (state_ff)
         ST_CELL_CMP: begin
            alu_a = ALU_W'(tbl_data.ca);
            alu_b = ALU_W'(tbl_data.cb);
         end
         ST_W_ADDP: begin
            alu_a = ALU_W'(wacc_ff);
            alu_b = ALU_W'(p_rd);
         end
         ST_W_ADDQ: begin
            alu_a = ALU_W'(wacc_ff);
            alu_b = ALU_W'(q_rd);
         end
         default: begin
            alu_a = ALU_W'(wacc_ff);
            alu_b = ALU_W'(best_ff);
         end
      endcase
   end

   // table read addresses
   always_comb begin
      if (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_OUT) begin
         tbl_rd.w_addr  = tbl_addr(i_ff, j_idx);
         tbl_rd.ca_addr = tbl_addr(i_ff, j_idx);
         tbl_rd.cb_addr = tbl_addr(i_ff, j_idx);
      end else begin
         tbl_rd.w_addr  = tbl_addr(i_ff, j_idx - IDX_W'(1));
         tbl_rd.ca_addr = tbl_addr(i_ff, m_ff - IDX_W'(1));
         tbl_rd.cb_addr = tbl_addr(m_ff, j_idx);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      load_pos_in   = load_pos_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      d_in          = d_ff;
      m_in          = m_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      wacc_in       = wacc_ff;
      tbl_wr.we     = 1'b0;
      tbl_wr.addr   = tbl_addr(i_ff, j_idx);
      tbl_wr.w      = wacc_ff;
      tbl_wr.c      = cost_sat;
      tbl_wr.r      = pick_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_final_in  = rsp_final_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (load_take) begin
               if (load_last) begin
                  n_in        = load_pos_ff;
                  load_pos_in = '0;
                  i_in        = '0;
                  d_in        = '0;
                  state_in    = ST_INIT;
               end else begin
                  load_pos_in = load_pos_ff + IDX_W'(1);
               end
            end
         end
         // diagonal: w = q[i], c = 0, r = 0
         ST_INIT: begin
            tbl_wr.we   = 1'b1;
            tbl_wr.addr = tbl_addr(i_ff, i_ff);
            tbl_wr.w    = SUM_W'(q_rd);
            tbl_wr.c    = '0;
            tbl_wr.r    = '0;
            i_in        = i_ff + IDX_W'(1);
            if (i_ff == n_ff) begin
               i_in = '0;
               if (n_ff == '0) begin
                  d_in     = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  d_in     = IDX_W'(1);
                  m_in     = IDX_W'(1);
                  state_in = ST_CELL_RD;
               end
            end
         end
         ST_CELL_RD: begin
            state_in = ST_CELL_CMP;
         end
         // candidate root m: keep the strictly smaller sum
         ST_CELL_CMP: begin
            if (first_cand || alu_lt) begin
               best_in = alu_sum[BEST_W-1:0];
               pick_in = m_ff;
            end
            if (first_cand) begin
               wacc_in = tbl_data.w;
            end
            m_in     = m_ff + IDX_W'(1);
            state_in = (m_ff == j_idx) ? ST_W_ADDP : ST_CELL_RD;
         end
         ST_W_ADDP: begin
            wacc_in  = alu_sum[SUM_W-1:0];
            state_in = ST_W_ADDQ;
         end
         ST_W_ADDQ: begin
            wacc_in  = alu_sum[SUM_W-1:0];
            state_in = ST_CELL_WR;
         end
         // store entry, move to next range
         ST_CELL_WR: begin
            tbl_wr.we = 1'b1;
            state_in  = ST_CELL_RD;
            if (j_idx == n_ff) begin
               i_in = '0;
               m_in = IDX_W'(1);
               if (d_ff == n_ff) begin
                  d_in     = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  d_in = d_ff + IDX_W'(1);
               end
            end else begin
               i_in = i_ff + IDX_W'(1);
               m_in = i_ff + IDX_W'(2);
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         // hand entry to the output register
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_left_in   = i_ff;
               rsp_right_in  = j_idx;
               rsp_weight_in = tbl_data.w;
               rsp_cost_in   = tbl_data.ca;
               rsp_root_in   = tbl_data.r;
               rsp_final_in  = (d_ff == n_ff);
               state_in      = ST_EMIT_RD;
               if (j_idx == n_ff) begin
                  i_in = '0;
                  if (d_ff == n_ff) begin
                     state_in = ST_LOAD;
                  end else begin
                     d_in = d_ff + IDX_W'(1);
                  end
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      d_ff          <= d_in;
      m_ff          <= m_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      wacc_ff       <= wacc_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_final_ff  <= rsp_final_in;
   end

   // weight stores
   always_ff @(posedge clock) begin
      if (load_take) begin
         p_store_ff[load_pos_ff] <= req_success_weight;
         q_store_ff[load_pos_ff] <= req_failure_weight;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_bound     = rsp_left_ff;
   assign rsp_right_bound    = rsp_right_ff;
   assign rsp_subtree_weight = rsp_weight_ff;
   assign rsp_subtree_cost   = rsp_cost_ff;
   assign rsp_best_root      = rsp_root_ff;
   assign rsp_final_entry    = rsp_final_ff;

endmodule
